### hw/rtl/sprite_tile_pixel_fetch_assert.svh
// Assertion macros used by the sprite tile pixel fetch back end.
`ifndef SPRITE_TILE_PIXEL_FETCH_ASSERT_SVH
`define SPRITE_TILE_PIXEL_FETCH_ASSERT_SVH

// Same-cycle implication, checked on aclk outside of reset.
`define STFP_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk outside of reset.
`define STFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> cons) \
        else $error(msg);

`endif

### hw/rtl/stfp_pkg.sv
// Shared types, constants and the sprite size table of the sprite tile pixel fetch.
package stfp_pkg;

    localparam int TILE_BYTES_DEFAULT = 32768;
    localparam int PALETTE_ENTRIES    = 256;
    localparam int QUEUE_DEPTH        = 2;

    localparam logic [1:0] OP_TILE_WR = 2'd0;
    localparam logic [1:0] OP_PAL_WR  = 2'd1;
    localparam logic [1:0] OP_FETCH   = 2'd2;

    localparam logic [1:0] KIND_TILE_WR = 2'd0;
    localparam logic [1:0] KIND_PAL_WR  = 2'd1;
    localparam logic [1:0] KIND_DONE    = 2'd2;
    localparam logic [1:0] KIND_FETCH   = 2'd3;

    typedef struct packed {
        logic       is_pixel;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [6:0] sprite_width;
        logic [6:0] sprite_height;
        logic       bad_shape;
        logic       outside_sprite;
    } stfp_result_t;

    typedef struct packed {
        logic [1:0]   kind;
        logic         color8;
        logic         nib_hi;
        logic [3:0]   bank;
        logic [14:0]  addr;
        logic [15:0]  wdata;
        stfp_result_t res;
    } stfp_entry_t;

    function automatic logic [13:0] size_lookup(input logic [3:0] sel);
        logic [13:0] wh;
        unique case (sel)
            4'd0:    wh = {7'd8,  7'd8};
            4'd1:    wh = {7'd16, 7'd16};
            4'd2:    wh = {7'd32, 7'd32};
            4'd3:    wh = {7'd64, 7'd64};
            4'd4:    wh = {7'd16, 7'd8};
            4'd5:    wh = {7'd32, 7'd8};
            4'd6:    wh = {7'd32, 7'd16};
            4'd7:    wh = {7'd64, 7'd32};
            4'd8:    wh = {7'd8,  7'd16};
            4'd9:    wh = {7'd8,  7'd32};
            4'd10:   wh = {7'd16, 7'd32};
            4'd11:   wh = {7'd32, 7'd64};
            default: wh = {7'd8,  7'd8};
        endcase
        return wh;
    endfunction

endpackage

### hw/rtl/sprite_tile_pixel_fetch.sv
// Sprite tile pixel fetch top level: a front end that decodes each request and forms the
// tile address, a two-entry queue, and a back end that owns the 32 KiB tile RAM and the
// 256-entry palette RAM. The back end works on one request at a time. A tile or palette
// write, an acknowledge or an out-of-range pixel goes from the queue straight into the
// result register, while a pixel fetch passes through the registered tile read and then
// the dependent registered palette read. The back end stays busy with a request until
// its result is taken from the output. The queue lets the input side keep accepting up
// to two requests while a result waits on the output. Both memories power up with
// unknown contents, and the user must use them only after being written; the block
// itself does not enforce this. There is no clearing pass.
module sprite_tile_pixel_fetch #(
    parameter int TILE_BYTES = stfp_pkg::TILE_BYTES_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,   // one_d_mapping
    input  logic        s_tvalid,
    output logic        s_tready,
    // write_address[14:0], write_data[30:15], attr_word0[46:31], attr_word1[62:47],
    // attr_word2[78:63], pixel_x[84:79], pixel_y[90:85], zero fill[95:91]
    input  logic [95:0] s_tdata,
    input  logic [1:0]  s_tuser,       // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // red[7:0], green[15:8], blue[23:16], sprite_width[30:24], sprite_height[37:31],
    // bad_shape[38], outside_sprite[39]
    output logic [39:0] m_tdata,
    output logic        m_tuser        // is_pixel
);

    import stfp_pkg::*;

    logic         one_d_mapping_reg;
    logic         push;
    logic         q_full;
    logic         q_valid;
    logic         q_pop;
    stfp_entry_t  front_entry;
    stfp_entry_t  q_head;
    stfp_result_t result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            one_d_mapping_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            one_d_mapping_reg <= cfg_wr_data;
        end
    end

    assign s_tready = !q_full;
    assign push     = s_tvalid && s_tready;

    stfp_front u_front (
        .one_d_mapping (one_d_mapping_reg),
        .operation     (s_tuser),
        .write_address (s_tdata[14:0]),
        .write_data    (s_tdata[30:15]),
        .attr_word0    (s_tdata[46:31]),
        .attr_word1    (s_tdata[62:47]),
        .attr_word2    (s_tdata[78:63]),
        .pixel_x       (s_tdata[84:79]),
        .pixel_y       (s_tdata[90:85]),
        .entry         (front_entry)
    );

    stfp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (front_entry),
        .full       (q_full),
        .pop        (q_pop),
        .valid      (q_valid),
        .head       (q_head)
    );

    stfp_back #(
        .TILE_BYTES (TILE_BYTES)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_entry  (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .result   (result)
    );

    assign m_tdata = {result.outside_sprite, result.bad_shape, result.sprite_height,
                      result.sprite_width, result.blue, result.green, result.red};
    assign m_tuser = result.is_pixel;

endmodule

### hw/rtl/stfp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module stfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/stfp_front.sv
// Front end: classifies each request and forms the tile address and size flags.
module stfp_front (
    input  logic               one_d_mapping,
    input  logic [1:0]         operation,
    input  logic [14:0]        write_address,
    input  logic [15:0]        write_data,
    input  logic [15:0]        attr_word0,
    input  logic [15:0]        attr_word1,
    input  logic [15:0]        attr_word2,
    input  logic [5:0]         pixel_x,
    input  logic [5:0]         pixel_y,
    output stfp_pkg::stfp_entry_t entry
);

    import stfp_pkg::*;

    logic [3:0]  sel;
    logic [13:0] wh;
    logic [6:0]  w;
    logic [6:0]  h;
    logic        bad;
    logic        outside;
    logic        color8;
    logic [9:0]  c;
    logic [5:0]  inc;
    logic [8:0]  row_off;
    logic [10:0] tile_sum;
    logic [16:0] addr8;
    logic [16:0] addr4;

    assign sel     = {attr_word0[15:14], attr_word1[15:14]};
    assign wh      = size_lookup(sel);
    assign bad     = (sel[3:2] == 2'b11);
    assign w       = bad ? 7'd8 : wh[13:7];
    assign h       = bad ? 7'd8 : wh[6:0];
    assign outside = !bad && (({1'b0, pixel_x} >= w) || ({1'b0, pixel_y} >= h));
    assign color8  = attr_word0[13];

    always_comb begin
        if (color8) begin
            inc = one_d_mapping ? {1'b0, w[6:2]} : 6'd32;
            c   = one_d_mapping ? attr_word2[9:0] : {attr_word2[9:1], 1'b0};
        end else begin
            inc = one_d_mapping ? {2'b0, w[6:3]} : 6'd32;
            c   = attr_word2[9:0];
        end
    end

    assign row_off  = 9'(pixel_y[5:3]) * 9'(inc);
    assign tile_sum = 11'(c) + 11'(row_off);
    assign addr8 = {1'b0, tile_sum, 5'b0} + 17'({pixel_y[2:0], 3'b0})
                 + 17'({pixel_x[5:3], 6'b0}) + 17'(pixel_x[2:0]);
    assign addr4 = {1'b0, tile_sum, 5'b0} + 17'({pixel_y[2:0], 2'b0})
                 + 17'({pixel_x[5:3], 5'b0}) + 17'(pixel_x[2:1]);

    always_comb begin
        entry        = '0;
        entry.color8 = color8;
        entry.nib_hi = pixel_x[0];
        entry.bank   = attr_word2[15:12];
        entry.wdata  = write_data;
        unique case (operation)
            OP_TILE_WR: begin
                entry.kind = KIND_TILE_WR;
                entry.addr = write_address;
            end
            OP_PAL_WR: begin
                entry.kind = KIND_PAL_WR;
                entry.addr = write_address;
            end
            OP_FETCH: begin
                entry.res.is_pixel       = 1'b1;
                entry.res.sprite_width   = w;
                entry.res.sprite_height  = h;
                entry.res.bad_shape      = bad;
                entry.res.outside_sprite = outside;
                entry.kind = (bad || outside) ? KIND_DONE : KIND_FETCH;
                entry.addr = color8 ? addr8[14:0] : addr4[14:0];
            end
            default: begin
                entry.kind = KIND_DONE;
            end
        endcase
    end

endmodule

### hw/rtl/stfp_queue.sv
// Short request queue between the front end and the back end.
module stfp_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  stfp_pkg::stfp_entry_t push_entry,
    output logic                  full,
    input  logic                  pop,
    output logic                  valid,
    output stfp_pkg::stfp_entry_t head
);

    import stfp_pkg::*;

    localparam int PtrW = $clog2(QUEUE_DEPTH);
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    stfp_entry_t       slots [QUEUE_DEPTH];
    logic [PtrW-1:0]   wr_ptr_reg;
    logic [PtrW-1:0]   wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg;
    logic [PtrW-1:0]   rd_ptr_next;
    logic [CntW-1:0]   count_reg;
    logic [CntW-1:0]   count_next;

    assign full  = (count_reg == CntW'(QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = slots[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### hw/rtl/stfp_back.sv
// Back end: performs store writes and the tile and palette reads of a pixel fetch.
module stfp_back #(
    parameter int TILE_BYTES = stfp_pkg::TILE_BYTES_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    input  stfp_pkg::stfp_entry_t  q_entry,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output stfp_pkg::stfp_result_t result
);

    import stfp_pkg::*;

    localparam int TileAddrW = $clog2(TILE_BYTES);
    localparam int PalAddrW  = $clog2(PALETTE_ENTRIES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_TILE = 2'd1;
    localparam logic [1:0] S_PAL  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    stfp_entry_t         entry_reg;
    stfp_entry_t         entry_next;
    stfp_result_t        res_reg;
    stfp_result_t        res_next;

    logic                tile_we;
    logic [7:0]          tile_rdata;
    logic                pal_we;
    logic [PalAddrW-1:0] pal_raddr;
    logic [15:0]         pal_rdata;

    assign q_pop    = (state_reg == S_IDLE) && q_valid;
    assign tile_we  = q_pop && (q_entry.kind == KIND_TILE_WR);
    assign pal_we   = q_pop && (q_entry.kind == KIND_PAL_WR);
    assign m_tvalid = (state_reg == S_OUT);
    assign result   = res_reg;

    always_comb begin
        if (entry_reg.color8) begin
            pal_raddr = tile_rdata;
        end else begin
            pal_raddr = {entry_reg.bank, entry_reg.nib_hi ? tile_rdata[7:4] : tile_rdata[3:0]};
        end
    end

    stfp_ram #(
        .WIDTH (8),
        .DEPTH (TILE_BYTES)
    ) u_tile_ram (
        .aclk  (aclk),
        .we    (tile_we),
        .waddr (q_entry.addr[TileAddrW-1:0]),
        .wdata (q_entry.wdata[7:0]),
        .raddr (q_entry.addr[TileAddrW-1:0]),
        .rdata (tile_rdata)
    );

    stfp_ram #(
        .WIDTH (16),
        .DEPTH (PALETTE_ENTRIES)
    ) u_pal_ram (
        .aclk  (aclk),
        .we    (pal_we),
        .waddr (q_entry.addr[PalAddrW-1:0]),
        .wdata (q_entry.wdata),
        .raddr (pal_raddr),
        .rdata (pal_rdata)
    );

    always_comb begin
        state_next = state_reg;
        entry_next = entry_reg;
        res_next   = res_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    entry_next = q_entry;
                    res_next   = q_entry.res;
                    state_next = (q_entry.kind == KIND_FETCH) ? S_TILE : S_OUT;
                end
            end
            S_TILE: begin
                state_next = S_PAL;
            end
            S_PAL: begin
                res_next.red   = {pal_rdata[4:0], 3'b0};
                res_next.green = {pal_rdata[9:5], 3'b0};
                res_next.blue  = {pal_rdata[14:10], 3'b0};
                state_next     = S_OUT;
            end
            S_OUT: begin
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        res_reg   <= res_next;
    end

`include "sprite_tile_pixel_fetch_assert.svh"

    `STFP_ASSERT_IMPLIES(ack_is_zero, m_tvalid && !res_reg.is_pixel, res_reg == '0, "write acknowledge carries nonzero fields")
    `STFP_ASSERT_IMPLIES(bad_shape_dark, m_tvalid && res_reg.bad_shape, res_reg.red == 8'd0 && res_reg.green == 8'd0 && res_reg.blue == 8'd0 && res_reg.sprite_width == 7'd8 && !res_reg.outside_sprite, "invalid shape result is malformed")
    `STFP_ASSERT_NEXT(fetch_latency, q_pop && q_entry.kind == KIND_FETCH, ##2 (state_reg == S_OUT), "pixel fetch did not reach the output in three cycles")

endmodule

### sim/tb_sprite_tile_pixel_fetch.sv
// Self-checking testbench for the sprite tile pixel fetch: stream stimulus, shadow stores, checks.
`timescale 1ns / 1ps

module tb_sprite_tile_pixel_fetch;
    import stfp_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 12;

    typedef struct packed {
        logic [1:0]  op;
        logic [14:0] wa;
        logic [15:0] wd;
        logic [15:0] a0;
        logic [15:0] a1;
        logic [15:0] a2;
        logic [5:0]  px;
        logic [5:0]  py;
    } request_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tuser;

    logic [7:0]  tile_image [0:32767];
    bit          tile_loaded [0:32767];
    logic [15:0] palette_image [0:255];
    bit          palette_loaded [0:255];
    bit          one_d_map;

    stfp_result_t pending_results[$];
    int error_count;
    int cycle_count;
    int stall_left;
    bit idle_enable;

    sprite_tile_pixel_fetch dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Returns {width, height} for a shape and size selector; codes 12 to 15 give 8 by 8.
    function automatic logic [13:0] decode_dims(input logic [3:0] sel);
        logic [6:0] w;
        logic [6:0] h;
        case (sel)
            4'd0:    begin w = 7'd8;  h = 7'd8;  end
            4'd1:    begin w = 7'd16; h = 7'd16; end
            4'd2:    begin w = 7'd32; h = 7'd32; end
            4'd3:    begin w = 7'd64; h = 7'd64; end
            4'd4:    begin w = 7'd16; h = 7'd8;  end
            4'd5:    begin w = 7'd32; h = 7'd8;  end
            4'd6:    begin w = 7'd32; h = 7'd16; end
            4'd7:    begin w = 7'd64; h = 7'd32; end
            4'd8:    begin w = 7'd8;  h = 7'd16; end
            4'd9:    begin w = 7'd8;  h = 7'd32; end
            4'd10:   begin w = 7'd16; h = 7'd32; end
            4'd11:   begin w = 7'd32; h = 7'd64; end
            default: begin w = 7'd8;  h = 7'd8;  end
        endcase
        return {w, h};
    endfunction

    function automatic logic [3:0] size_select(input request_t r);
        return {r.a0[15:14], r.a1[15:14]};
    endfunction

    function automatic bit fetch_reads_memory(input request_t r);
        logic [13:0] dims;
        dims = decode_dims(size_select(r));
        return (size_select(r) < 4'd12) && (r.px < dims[13:7]) && (r.py < dims[6:0]);
    endfunction

    function automatic logic [14:0] tile_byte_addr(input request_t r);
        logic [13:0] dims;
        int w;
        int c;
        int inc;
        int x;
        int y;
        int a;
        dims = decode_dims(size_select(r));
        w = dims[13:7];
        c = r.a2[9:0];
        x = r.px;
        y = r.py;
        if (r.a0[13]) begin
            if (one_d_map) begin
                inc = w >> 2;
            end else begin
                inc = 32;
                c = c & 'h3FE;
            end
            a = (c + (y >> 3) * inc) * 32 + (y & 7) * 8 + (x >> 3) * 64 + (x & 7);
        end else begin
            inc = one_d_map ? (w >> 3) : 32;
            a = (c + (y >> 3) * inc) * 32 + (y & 7) * 4 + (x >> 3) * 32 + ((x & 7) >> 1);
        end
        return a[14:0];
    endfunction

    function automatic logic [7:0] palette_index(input request_t r, input logic [7:0] tile_byte);
        if (r.a0[13]) begin
            return tile_byte;
        end
        return {r.a2[15:12], r.px[0] ? tile_byte[7:4] : tile_byte[3:0]};
    endfunction

    // Applies one request to the shadow stores and returns the result it must produce.
    function automatic stfp_result_t model_request(input request_t r);
        stfp_result_t res;
        logic [13:0]  dims;
        logic [14:0]  addr;
        logic [15:0]  color;
        res = '0;
        case (r.op)
            OP_TILE_WR: begin
                tile_image[r.wa] = r.wd[7:0];
                tile_loaded[r.wa] = 1'b1;
            end
            OP_PAL_WR: begin
                palette_image[r.wa[7:0]] = r.wd;
                palette_loaded[r.wa[7:0]] = 1'b1;
            end
            OP_FETCH: begin
                dims = decode_dims(size_select(r));
                res.is_pixel = 1'b1;
                res.sprite_width = dims[13:7];
                res.sprite_height = dims[6:0];
                if (size_select(r) >= 4'd12) begin
                    res.bad_shape = 1'b1;
                end else if (!fetch_reads_memory(r)) begin
                    res.outside_sprite = 1'b1;
                end else begin
                    addr = tile_byte_addr(r);
                    color = palette_image[palette_index(r, tile_image[addr])];
                    res.red = {color[4:0], 3'b000};
                    res.green = {color[9:5], 3'b000};
                    res.blue = {color[14:10], 3'b000};
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic request_t make_req(input logic [1:0] op, input logic [14:0] wa,
                                          input logic [15:0] wd, input logic [15:0] a0,
                                          input logic [15:0] a1, input logic [15:0] a2,
                                          input logic [5:0] px, input logic [5:0] py);
        request_t r;
        r.op = op;
        r.wa = wa;
        r.wd = wd;
        r.a0 = a0;
        r.a1 = a1;
        r.a2 = a2;
        r.px = px;
        r.py = py;
        return r;
    endfunction

    function automatic request_t random_req(input logic [1:0] op);
        return make_req(op, 15'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 6'($urandom), 6'($urandom));
    endfunction

    task automatic report_mismatch(input string what, input logic [39:0] want,
                                   input logic [39:0] got);
        $display("mismatch on %s: expected %0h, got %0h", what, want, got);
        error_count++;
    endtask

    task automatic send_request(input request_t r);
        stfp_result_t res;
        if (idle_enable && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        res = model_request(r);
        pending_results.push_back(res);
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, r.py, r.px, r.a2, r.a1, r.a0, r.wd, r.wa};
        s_tuser <= r.op;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Loads the tile byte and palette entry a fetch will read, when they are still unwritten.
    task automatic send_fetch(input logic [15:0] a0, input logic [15:0] a1, input logic [15:0] a2,
                              input logic [5:0] px, input logic [5:0] py);
        request_t r;
        request_t w;
        logic [14:0] addr;
        logic [7:0] idx;
        r = make_req(OP_FETCH, 15'($urandom), 16'($urandom), a0, a1, a2, px, py);
        if (fetch_reads_memory(r)) begin
            addr = tile_byte_addr(r);
            if (!tile_loaded[addr]) begin
                w = random_req(OP_TILE_WR);
                w.wa = addr;
                send_request(w);
            end
            idx = palette_index(r, tile_image[addr]);
            if (!palette_loaded[idx]) begin
                w = random_req(OP_PAL_WR);
                w.wa[7:0] = idx;
                send_request(w);
            end
        end
        send_request(r);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_mapping(input bit value);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        one_d_map = value;
    endtask

    task automatic check_result();
        stfp_result_t want;
        if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", 40'd0, m_tdata);
            return;
        end
        want = pending_results.pop_front();
        if (m_tuser !== want.is_pixel) report_mismatch("is_pixel", want.is_pixel, m_tuser);
        if (m_tdata[7:0] !== want.red) report_mismatch("red", want.red, m_tdata[7:0]);
        if (m_tdata[15:8] !== want.green) report_mismatch("green", want.green, m_tdata[15:8]);
        if (m_tdata[23:16] !== want.blue) report_mismatch("blue", want.blue, m_tdata[23:16]);
        if (m_tdata[30:24] !== want.sprite_width)
            report_mismatch("sprite_width", want.sprite_width, m_tdata[30:24]);
        if (m_tdata[37:31] !== want.sprite_height)
            report_mismatch("sprite_height", want.sprite_height, m_tdata[37:31]);
        if (m_tdata[38] !== want.bad_shape)
            report_mismatch("bad_shape", want.bad_shape, m_tdata[38]);
        if (m_tdata[39] !== want.outside_sprite)
            report_mismatch("outside_sprite", want.outside_sprite, m_tdata[39]);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            check_result();
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 4);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic test_directed();
        set_mapping(1'b0);
        send_request(make_req(OP_UNUSED, '1, '1, '1, '1, '1, '1, '1));
        send_request(make_req(OP_UNUSED, '0, '0, '0, '0, '0, '0, '0));
        send_request(make_req(OP_TILE_WR, 15'h7FFF, 16'hFFFF, '1, '1, '1, '1, '1));
        send_request(make_req(OP_TILE_WR, 15'h0000, 16'h5A3C, '0, '0, '0, '0, '0));
        send_request(make_req(OP_PAL_WR, 15'h7FFF, 16'hFFFF, '1, '1, '1, '1, '1));
        send_request(make_req(OP_PAL_WR, 15'h0100, 16'h0000, '0, '0, '0, '0, '0));
        send_fetch(16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd63, 6'd63);
        send_fetch(16'hC000, 16'h0000, 16'h0000, 6'd0, 6'd0);
        send_fetch(16'h0000, 16'h0000, 16'h0000, 6'd8, 6'd0);
        send_fetch(16'h0000, 16'h0000, 16'h0000, 6'd0, 6'd8);
        send_fetch(16'h0000, 16'h0000, 16'h0000, 6'd63, 6'd63);
        send_fetch(16'h0000, 16'h0000, 16'hF000, 6'd0, 6'd0);
        send_fetch(16'h0000, 16'h0000, 16'hF000, 6'd1, 6'd0);
        send_fetch(16'h2000, 16'hC000, 16'h03FF, 6'd63, 6'd63);
        send_fetch(16'h0000, 16'hC000, 16'hF3FF, 6'd63, 6'd63);
        send_fetch(16'h6000, 16'hC000, 16'h03FF, 6'd63, 6'd31);
        send_fetch(16'h8000, 16'hC000, 16'h03FF, 6'd31, 6'd63);
        set_mapping(1'b1);
        send_fetch(16'h2000, 16'hC000, 16'h03FF, 6'd63, 6'd63);
        send_fetch(16'h0000, 16'hC000, 16'hF3FF, 6'd63, 6'd63);
        send_fetch(16'h6000, 16'h4000, 16'h0155, 6'd31, 6'd7);
    endtask

    // Half the requests are fetches that land inside a valid sprite; the rest are random fetches, writes and noise.
    task automatic test_random(input int count, input bit mapping);
        int pick;
        logic [1:0] shape;
        logic [1:0] size_code;
        logic [13:0] dims;
        request_t r;
        set_mapping(mapping);
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                shape = 2'($urandom_range(0, 2));
                size_code = 2'($urandom_range(0, 3));
                dims = decode_dims({shape, size_code});
                send_fetch({shape, 14'($urandom)}, {size_code, 14'($urandom)}, 16'($urandom),
                           6'($urandom_range(0, dims[13:7] - 1)),
                           6'($urandom_range(0, dims[6:0] - 1)));
            end else if (pick < 60) begin
                r = random_req(OP_FETCH);
                send_fetch(r.a0, r.a1, r.a2, r.px, r.py);
            end else if (pick < 78) begin
                send_request(random_req(OP_TILE_WR));
            end else if (pick < 93) begin
                send_request(random_req(OP_PAL_WR));
            end else begin
                send_request(random_req(OP_UNUSED));
            end
        end
    endtask

    task automatic test_back_to_back();
        idle_enable = 1'b0;
        test_random(70, 1'($urandom_range(0, 1)));
    endtask

    initial begin
        aresetn <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        one_d_map = 1'b0;
        idle_enable = 1'b1;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(90, 1'b1);
        test_random(90, 1'b0);
        test_random(90, 1'b1);
        test_back_to_back();
        drain_results();
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/stfp_pkg.sv
hw/rtl/stfp_ram.sv
hw/rtl/stfp_front.sv
hw/rtl/stfp_queue.sv
hw/rtl/stfp_back.sv
hw/rtl/sprite_tile_pixel_fetch.sv
sim/tb_sprite_tile_pixel_fetch.sv
